// ===== rtl/hnss_pkg.sv =====
// ----------------------------------------------------------------------------
// hnss_pkg
// Shared types, constants and helpers for the H.265 Annex B stream splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package hnss_pkg;

  // Output route codes.
  typedef enum logic [1:0] {
    ROUTE_PACKET = 2'd0,
    ROUTE_PARAMS = 2'd1,
    ROUTE_SEI    = 2'd2
  } route_e;

  // Header byte mask ahead of the type field extraction.
  localparam logic [7:0] HDR_TYPE_MASK = 8'h7F;

  // Unit type codes and ranges.
  localparam logic [5:0] TYPE_VPS        = 6'd32;
  localparam logic [5:0] TYPE_PPS        = 6'd34;
  localparam logic [5:0] TYPE_SEI_PREFIX = 6'd39;
  localparam logic [5:0] TYPE_SEI_SUFFIX = 6'd40;
  localparam logic [5:0] TYPE_IRAP_LO    = 6'd16;
  localparam logic [5:0] TYPE_VCL_HI     = 6'd23;

  // Start code bytes.
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  // Zero run saturates at three held zeros.
  localparam logic [1:0] ZERO_RUN_MAX = 2'd3;

  // Six-bit unit type from a header byte.
  function automatic logic [5:0] unit_type(input logic [7:0] hdr);
    logic [7:0] masked;
    masked = hdr & HDR_TYPE_MASK;
    return masked[6:1];
  endfunction

  // Route selected by a unit type.
  function automatic route_e route_of_type(input logic [5:0] ty);
    route_e r;
    r = ROUTE_PACKET;
    if (ty >= TYPE_VPS && ty <= TYPE_PPS) begin
      r = ROUTE_PARAMS;
    end else if (ty == TYPE_SEI_PREFIX || ty == TYPE_SEI_SUFFIX) begin
      r = ROUTE_SEI;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hevc_nal_stream_splitter.sv =====
// ----------------------------------------------------------------------------
// hevc_nal_stream_splitter
// Finds 00 00 01 start codes in an H.265 Annex B byte stream and routes
// every unit byte to packet data, parameter sets or SEI.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------
//   input   | in        | in_valid_i / in_stall_o  | data_byte_i, last_byte_i
//   output  | out       | out_valid_o / out_stall_i| out_byte_o, route_o,
//           |           |                          | byte_valid_o, packet_done_o,
//           |           |                          | is_keyframe_o
//
// An accepted byte updates the parser state and loads a job register with the
// results it releases (held zeros, a start code one, the byte, an end marker).
// The job register sends one result per cycle to the output register while
// the output is not stalled; a byte with no results never enters it. The next
// byte is taken in the cycle the final result leaves. Reset clears the parser,
// the job register and the output valid; a stalled output stalls the input.
//
`default_nettype none

module hevc_nal_stream_splitter (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      route_o,
  output logic            byte_valid_o,
  output logic            packet_done_o,
  output logic            is_keyframe_o
);

  // --------------------------------------------------------------------------
  // Parser state. in_unit_q is set once the first unit header has been taken.
  // zero_run_q counts zeros held back because they may open a start code.
  // --------------------------------------------------------------------------
  logic                in_unit_q, in_unit_d;
  logic [1:0]          zero_run_q, zero_run_d;
  logic                pending_q, pending_d;
  hnss_pkg::route_e    cur_route_q, cur_route_d;
  logic                key_decided_q, key_decided_d;
  logic                key_value_q, key_value_d;

  // --------------------------------------------------------------------------
  // Job register: what the last accepted byte still has to emit, in order:
  // job_zeros_q zero bytes, then an optional 01, then the byte itself, or a
  // lone end-of-packet marker when the final byte produced nothing.
  // --------------------------------------------------------------------------
  logic                job_valid_q, job_valid_d;
  logic [2:0]          job_zeros_q, job_zeros_d;
  logic                job_one_q, job_one_d;
  logic                job_byte_q, job_byte_d;
  logic                job_mark_q, job_mark_d;
  logic [7:0]          job_data_q, job_data_d;
  hnss_pkg::route_e    job_route_q, job_route_d;
  logic                job_last_q, job_last_d;
  logic                job_key_q, job_key_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q, out_byte_d;
  hnss_pkg::route_e    out_route_q, out_route_d;
  logic                out_bvalid_q, out_bvalid_d;
  logic                out_done_q, out_done_d;
  logic                out_key_q, out_key_d;

  // Handshake and emission control.
  logic                out_ready;
  logic                emit;
  logic                job_empty_next;
  logic                emit_last;
  logic                accept;

  // Descriptor built from the incoming byte.
  logic [5:0]          hdr_type;
  hnss_pkg::route_e    new_route;
  logic [2:0]          new_zeros;
  logic                new_one;
  logic                new_byte;
  logic                new_mark;
  logic                new_key;
  logic                has_result;

  // Next job contents after one result leaves.
  logic [2:0]          step_zeros;
  logic                step_one;
  logic                step_byte;
  logic                step_mark;

  // --------------------------------------------------------------------------
  // Emission: one result per cycle whenever the output register can take it.
  // --------------------------------------------------------------------------
  assign out_ready = !out_valid_q || !out_stall_i;
  assign emit      = job_valid_q && out_ready;

  always_comb begin
    step_zeros = job_zeros_q;
    step_one   = job_one_q;
    step_byte  = job_byte_q;
    step_mark  = job_mark_q;
    if (job_zeros_q != 3'd0) begin
      step_zeros = job_zeros_q - 3'd1;
    end else if (job_one_q) begin
      step_one = 1'b0;
    end else if (job_byte_q) begin
      step_byte = 1'b0;
    end else begin
      step_mark = 1'b0;
    end
  end

  assign job_empty_next = (step_zeros == 3'd0) && !step_one && !step_byte && !step_mark;
  assign emit_last      = emit && job_empty_next;
  assign in_stall_o     = job_valid_q && !emit_last;
  assign accept         = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Parser: decides, for the incoming byte, which results it releases and
  // how the start code state moves on.
  // --------------------------------------------------------------------------
  assign hdr_type  = hnss_pkg::unit_type(data_byte_i);
  assign new_route = hnss_pkg::route_of_type(hdr_type);

  always_comb begin
    in_unit_d     = in_unit_q;
    zero_run_d    = zero_run_q;
    pending_d     = pending_q;
    cur_route_d   = cur_route_q;
    key_decided_d = key_decided_q;
    key_value_d   = key_value_q;
    new_zeros     = 3'd0;
    new_one       = 1'b0;
    new_byte      = 1'b0;

    if (pending_q) begin
      // Header byte: the held zeros, the 01 and the header go out on the
      // route the header selects.
      cur_route_d = new_route;
      new_zeros   = {1'b0, zero_run_q};
      new_one     = 1'b1;
      new_byte    = 1'b1;
      if (!key_decided_q && hdr_type <= hnss_pkg::TYPE_VCL_HI) begin
        key_decided_d = 1'b1;
        key_value_d   = (hdr_type >= hnss_pkg::TYPE_IRAP_LO);
      end
      pending_d  = 1'b0;
      in_unit_d  = 1'b1;
      zero_run_d = 2'd0;
    end else if (data_byte_i == hnss_pkg::BYTE_ZERO) begin
      // A fourth zero pushes the oldest held zero out to the current unit.
      if (zero_run_q == hnss_pkg::ZERO_RUN_MAX) begin
        new_zeros = {2'b00, in_unit_q};
      end else begin
        zero_run_d = zero_run_q + 2'd1;
      end
      // At the end of the packet the held zeros belong to the current unit.
      if (last_byte_i && in_unit_q) begin
        new_zeros = new_zeros + {1'b0, zero_run_d};
      end
    end else if (data_byte_i == hnss_pkg::BYTE_ONE && zero_run_q >= 2'd2) begin
      pending_d = 1'b1;
    end else begin
      if (in_unit_q) begin
        new_zeros = {1'b0, zero_run_q};
        new_byte  = 1'b1;
      end
      zero_run_d = 2'd0;
    end

    new_key    = key_decided_d && key_value_d;
    has_result = (new_zeros != 3'd0) || new_one || new_byte;
    new_mark   = last_byte_i && !has_result;

    // The packet ends here: everything goes back to its reset value.
    if (last_byte_i) begin
      in_unit_d     = 1'b0;
      zero_run_d    = 2'd0;
      pending_d     = 1'b0;
      cur_route_d   = hnss_pkg::ROUTE_PACKET;
      key_decided_d = 1'b0;
      key_value_d   = 1'b0;
    end

    if (!accept) begin
      in_unit_d     = in_unit_q;
      zero_run_d    = zero_run_q;
      pending_d     = pending_q;
      cur_route_d   = cur_route_q;
      key_decided_d = key_decided_q;
      key_value_d   = key_value_q;
    end
  end

  // --------------------------------------------------------------------------
  // Job register next state. A new job replaces a finished one in the same
  // cycle; bytes with nothing to emit never occupy it.
  // --------------------------------------------------------------------------
  always_comb begin
    job_valid_d = job_valid_q;
    job_zeros_d = job_zeros_q;
    job_one_d   = job_one_q;
    job_byte_d  = job_byte_q;
    job_mark_d  = job_mark_q;
    job_data_d  = job_data_q;
    job_route_d = job_route_q;
    job_last_d  = job_last_q;
    job_key_d   = job_key_q;
    if (accept) begin
      job_valid_d = has_result || new_mark;
      job_zeros_d = new_zeros;
      job_one_d   = new_one;
      job_byte_d  = new_byte;
      job_mark_d  = new_mark;
      job_data_d  = data_byte_i;
      job_route_d = pending_q ? new_route : cur_route_q;
      job_last_d  = last_byte_i;
      job_key_d   = new_key;
    end else if (emit) begin
      job_valid_d = !job_empty_next;
      job_zeros_d = step_zeros;
      job_one_d   = step_one;
      job_byte_d  = step_byte;
      job_mark_d  = step_mark;
    end
  end

  // --------------------------------------------------------------------------
  // Output register next state.
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_route_d  = out_route_q;
    out_bvalid_d = out_bvalid_q;
    out_done_d   = out_done_q;
    out_key_d    = out_key_q;
    if (out_ready) begin
      out_valid_d  = emit;
      out_bvalid_d = 1'b1;
      out_route_d  = job_route_q;
      if (job_zeros_q != 3'd0) begin
        out_byte_d = hnss_pkg::BYTE_ZERO;
      end else if (job_one_q) begin
        out_byte_d = hnss_pkg::BYTE_ONE;
      end else if (job_byte_q) begin
        out_byte_d = job_data_q;
      end else begin
        // End marker without a routed byte.
        out_byte_d   = hnss_pkg::BYTE_ZERO;
        out_route_d  = hnss_pkg::ROUTE_PACKET;
        out_bvalid_d = 1'b0;
      end
      out_done_d = job_last_q && job_empty_next;
      out_key_d  = job_last_q && job_empty_next && job_key_q;
    end
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_unit_q     <= 1'b0;
      zero_run_q    <= 2'd0;
      pending_q     <= 1'b0;
      cur_route_q   <= hnss_pkg::ROUTE_PACKET;
      key_decided_q <= 1'b0;
      key_value_q   <= 1'b0;
      job_valid_q   <= 1'b0;
      job_zeros_q   <= 3'd0;
      job_one_q     <= 1'b0;
      job_byte_q    <= 1'b0;
      job_mark_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      in_unit_q     <= in_unit_d;
      zero_run_q    <= zero_run_d;
      pending_q     <= pending_d;
      cur_route_q   <= cur_route_d;
      key_decided_q <= key_decided_d;
      key_value_q   <= key_value_d;
      job_valid_q   <= job_valid_d;
      job_zeros_q   <= job_zeros_d;
      job_one_q     <= job_one_d;
      job_byte_q    <= job_byte_d;
      job_mark_q    <= job_mark_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_data_q   <= job_data_d;
    job_route_q  <= job_route_d;
    job_last_q   <= job_last_d;
    job_key_q    <= job_key_d;
    out_byte_q   <= out_byte_d;
    out_route_q  <= out_route_d;
    out_bvalid_q <= out_bvalid_d;
    out_done_q   <= out_done_d;
    out_key_q    <= out_key_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign route_o       = out_route_q;
  assign byte_valid_o  = out_bvalid_q;
  assign packet_done_o = out_done_q;
  assign is_keyframe_o = out_key_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // A result without a routed byte only ever closes a packet, on route zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> packet_done_o && route_o == hnss_pkg::ROUTE_PACKET)
    else $error("blank result that does not close a packet");

  // An occupied job register always has something left to emit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (job_zeros_q != 3'd0) || job_one_q || job_byte_q || job_mark_q)
    else $error("job register occupied but empty");

  // Four held zeros is the most a single byte can release.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> job_zeros_q <= 3'd4)
    else $error("job zero count out of range");

  // Accepting the final byte of a packet returns the parser to its start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_byte_i |=> !in_unit_q && zero_run_q == 2'd0 && !pending_q
                              && !key_decided_q)
    else $error("parser state not cleared at packet end");

endmodule

`default_nettype wire

// ===== test/tb_hevc_nal_stream_splitter.sv =====
// ----------------------------------------------------------------------------
// tb_hevc_nal_stream_splitter
// Self-checking bench for the Annex B splitter: drives packet bytes, predicts
// the routed output of each transfer and compares every result as it leaves.
// ----------------------------------------------------------------------------
module tb_hevc_nal_stream_splitter;

  timeunit 1ns;
  timeprecision 1ps;

  // One routed result as the block presents it.
  typedef struct {
    logic [7:0]       data;
    hnss_pkg::route_e route;
    logic             valid;
    logic             done;
    logic             key;
  } routed_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       last_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic [1:0] route_o;
  logic       byte_valid_o;
  logic       packet_done_o;
  logic       is_keyframe_o;

  hevc_nal_stream_splitter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .route_o      (route_o),
    .byte_valid_o (byte_valid_o),
    .packet_done_o(packet_done_o),
    .is_keyframe_o(is_keyframe_o)
  );

  // Expected routed results, oldest first, plus the results of one byte.
  routed_t    routed_exp_q[$];
  routed_t    step_q[$];
  // Bytes of the packet being sent.
  logic [7:0] byte_q[$];

  // Parser image kept by the bench. It mirrors the block's view of the
  // stream: inside a unit or not, zeros held back that may still turn out
  // to open a start code, and a start code waiting for its header byte.
  bit               in_unit     = 1'b0;
  int               held_zeros  = 0;
  bit               header_due  = 1'b0;
  hnss_pkg::route_e unit_route  = hnss_pkg::ROUTE_PACKET;
  bit               key_known   = 1'b0;
  bit               key_flag    = 1'b0;

  bit         idle_on     = 1'b1;
  int         errors      = 0;
  int         bytes_sent  = 0;
  int         results_seen = 0;
  int         packets_done = 0;
  int         keyframes   = 0;
  int         route_hits[3] = '{0, 0, 0};

  // Clock with a 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #5_000_000;
    $display("Timeout at %0t with %0d results still expected", $time, routed_exp_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // Queue one routed byte on the route of the current unit.
  function automatic void put_byte(input logic [7:0] value);
    routed_t r;
    r.data  = value;
    r.route = unit_route;
    r.valid = 1'b1;
    r.done  = 1'b0;
    r.key   = 1'b0;
    step_q.push_back(r);
  endfunction

  // Work out every result caused by one accepted byte and append them to the
  // expected stream. The header byte after a start code picks the route for
  // the whole unit, so held zeros and the start code one are emitted only
  // once the header is known.
  function automatic void predict_routing(input logic [7:0] b, input logic last);
    logic [5:0] hdr_type;
    routed_t    tail;
    step_q.delete();
    if (header_due) begin
      hdr_type = b[6:1];
      if (hdr_type >= hnss_pkg::TYPE_VPS && hdr_type <= hnss_pkg::TYPE_PPS) begin
        unit_route = hnss_pkg::ROUTE_PARAMS;
      end else if (hdr_type == hnss_pkg::TYPE_SEI_PREFIX ||
                   hdr_type == hnss_pkg::TYPE_SEI_SUFFIX) begin
        unit_route = hnss_pkg::ROUTE_SEI;
      end else begin
        unit_route = hnss_pkg::ROUTE_PACKET;
      end
      repeat (held_zeros) put_byte(hnss_pkg::BYTE_ZERO);
      put_byte(hnss_pkg::BYTE_ONE);
      put_byte(b);
      // Only the first unit of a coded slice type decides the keyframe flag.
      if (!key_known && hdr_type <= hnss_pkg::TYPE_VCL_HI) begin
        key_known = 1'b1;
        key_flag  = (hdr_type >= hnss_pkg::TYPE_IRAP_LO);
      end
      header_due = 1'b0;
      in_unit    = 1'b1;
      held_zeros = 0;
    end else if (b == hnss_pkg::BYTE_ZERO) begin
      // A fourth zero pushes the oldest held zero out to the current unit.
      if (held_zeros >= 3) begin
        held_zeros = 3;
        if (in_unit) put_byte(hnss_pkg::BYTE_ZERO);
      end else begin
        held_zeros++;
      end
    end else if (b == hnss_pkg::BYTE_ONE && held_zeros >= 2) begin
      header_due = 1'b1;
    end else begin
      if (in_unit) begin
        repeat (held_zeros) put_byte(hnss_pkg::BYTE_ZERO);
        put_byte(b);
      end
      held_zeros = 0;
    end

    if (last) begin
      // Trailing zeros belong to the open unit; a start code with no header
      // is dropped along with its zeros.
      if (in_unit && !header_due) begin
        repeat (held_zeros) put_byte(hnss_pkg::BYTE_ZERO);
      end
      if (step_q.size() == 0) begin
        tail.data  = 8'h00;
        tail.route = hnss_pkg::ROUTE_PACKET;
        tail.valid = 1'b0;
        tail.done  = 1'b0;
        tail.key   = 1'b0;
        step_q.push_back(tail);
      end
      tail      = step_q.pop_back();
      tail.done = 1'b1;
      tail.key  = key_known && key_flag;
      step_q.push_back(tail);
      in_unit    = 1'b0;
      held_zeros = 0;
      header_due = 1'b0;
      unit_route = hnss_pkg::ROUTE_PACKET;
      key_known  = 1'b0;
      key_flag   = 1'b0;
    end

    foreach (step_q[i]) routed_exp_q.push_back(step_q[i]);
  endfunction

  // Result checker: every output transfer is compared with the oldest
  // expectation. Values are read at the rising edge, before the block's
  // registers take their new values.
  always @(posedge clk_i) begin
    routed_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (routed_exp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result byte=%02h route=%0d valid=%0b done=%0b key=%0b",
                 $time, out_byte_o, route_o, byte_valid_o, packet_done_o, is_keyframe_o);
      end else begin
        e = routed_exp_q.pop_front();
        if (out_byte_o !== e.data || route_o !== e.route || byte_valid_o !== e.valid ||
            packet_done_o !== e.done || is_keyframe_o !== e.key) begin
          errors++;
          $display("%0t: mismatch expected byte=%02h route=%0d valid=%0b done=%0b key=%0b",
                   $time, e.data, e.route, e.valid, e.done, e.key);
          $display("%0t:          actual   byte=%02h route=%0d valid=%0b done=%0b key=%0b",
                   $time, out_byte_o, route_o, byte_valid_o, packet_done_o, is_keyframe_o);
        end
        if (e.valid) route_hits[e.route]++;
        if (e.done) begin
          packets_done++;
          if (e.key) keyframes++;
        end
      end
    end
  end

  // Output back-pressure: random stall bursts while idling is enabled,
  // otherwise the sink always takes the result.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // Send one byte. The task is entered and left at a falling edge; valid is
  // left high so that back-to-back transfers need a single assignment.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_routing(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Send the bytes of byte_q as one packet, the last one flagged.
  task automatic send_packet();
    foreach (byte_q[i]) send_byte(byte_q[i], i == byte_q.size() - 1);
  endtask

  // Hold the input off until the block has delivered everything expected.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (routed_exp_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Byte value biased toward the values that matter for start codes.
  function automatic logic [7:0] stream_byte();
    case ($urandom_range(0, 4))
      0, 1:    return hnss_pkg::BYTE_ZERO;
      2:       return hnss_pkg::BYTE_ONE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build a well-formed packet with random content: optional junk ahead of
  // the first start code, one to four units with three- or four-byte start
  // codes, headers spread over all routes, and now and then a dangling start
  // code at the end.
  function automatic void build_packet();
    int         units;
    logic [5:0] ty;
    logic       hi_bit;
    logic       lo_bit;
    byte_q.delete();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) byte_q.push_back(stream_byte());
    end
    units = $urandom_range(1, 4);
    repeat (units) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) byte_q.push_back(hnss_pkg::BYTE_ZERO);
      end
      if ($urandom_range(0, 1)) byte_q.push_back(hnss_pkg::BYTE_ZERO);
      byte_q.push_back(hnss_pkg::BYTE_ZERO);
      byte_q.push_back(hnss_pkg::BYTE_ZERO);
      byte_q.push_back(hnss_pkg::BYTE_ONE);
      case ($urandom_range(0, 4))
        0:       ty = 6'($urandom_range(0, 15));
        1:       ty = 6'($urandom_range(16, 23));
        2:       ty = 6'($urandom_range(32, 34));
        3:       ty = $urandom_range(0, 1) ? hnss_pkg::TYPE_SEI_PREFIX
                                           : hnss_pkg::TYPE_SEI_SUFFIX;
        default: ty = 6'($urandom_range(0, 63));
      endcase
      hi_bit = 1'($urandom_range(0, 1));
      lo_bit = 1'($urandom_range(0, 1));
      byte_q.push_back({hi_bit, ty, lo_bit});
      repeat ($urandom_range(0, 6)) byte_q.push_back(stream_byte());
    end
    if ($urandom_range(0, 7) == 0) begin
      byte_q.push_back(hnss_pkg::BYTE_ZERO);
      byte_q.push_back(hnss_pkg::BYTE_ZERO);
      byte_q.push_back(hnss_pkg::BYTE_ONE);
    end
  endfunction

  // Bytes ahead of any start code are dropped; a last byte that routes
  // nothing still closes the packet with an empty result.
  task automatic test_drop_before_start();
    byte_q = '{8'hFF, 8'h00};
    send_packet();
  endtask

  // Headers of value 00 and 01, a long zero run inside a unit that spills
  // its oldest zeros, and trailing zeros flushed at the end of the packet.
  task automatic test_zero_runs_and_odd_headers();
    byte_q = '{8'h00, 8'h00, 8'h01, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
               8'h00, 8'h00};
    send_packet();
  endtask

  // Parameter set, SEI and IRAP units in one packet, closed by a start code
  // that never gets its header byte.
  task automatic test_routes_and_dangling_code();
    byte_q = '{8'h00, 8'h00, 8'h01, 8'h40,
               8'h00, 8'h00, 8'h01, 8'h4E,
               8'h00, 8'h00, 8'h01, 8'hA6,
               8'h00, 8'h00, 8'h01};
    send_packet();
  endtask

  // Random well-formed packets with idling on both sides. Halfway the sender
  // holds off until every expected result has come out.
  task automatic test_random_packets();
    bit paused;
    paused = 1'b0;
    while (bytes_sent < 300) begin
      build_packet();
      send_packet();
      if (!paused && bytes_sent >= 150) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // Unstructured byte noise, including broken start codes.
  task automatic test_noise_packets();
    while (bytes_sent < 360) begin
      byte_q.delete();
      repeat ($urandom_range(1, 20)) byte_q.push_back(stream_byte());
      send_packet();
    end
  endtask

  // The last stretch runs at full rate with no idling on either side.
  task automatic test_full_rate_tail();
    idle_on = 1'b0;
    while (bytes_sent < 445) begin
      build_packet();
      send_packet();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    last_byte_i = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_drop_before_start();
    test_zero_runs_and_odd_headers();
    test_routes_and_dangling_code();
    test_random_packets();
    test_noise_packets();
    test_full_rate_tail();

    in_valid_i <= 1'b0;
    while (routed_exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d results over %0d packets (%0d keyframes).",
             bytes_sent, results_seen, packets_done, keyframes);
    $display("Routed bytes: packet data %0d, parameter sets %0d, SEI %0d.",
             route_hits[0], route_hits[1], route_hits[2]);
    if (errors == 0 && routed_exp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, routed_exp_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
